// ----- rtl/core/button_press_length_classifier_core_assert.svh -----
// Assertion helpers for the button classifier core.
// The assertions sample on clk and are disabled while rst_n is low.
`ifndef BUTTON_PRESS_LENGTH_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_PRESS_LENGTH_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BPLC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bplc assertion failed");
`define BPLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bplc assertion failed");
`else
`define BPLC_ASSERT_SAME(label, ante, cons)
`define BPLC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/bplc_pkg.sv -----
package bplc_pkg;

  localparam int RING_DEPTH = 4;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam int KEY_W  = 7;
  localparam int CODE_W = 8;
  localparam int THR_W  = 10;
  localparam int CNT_W  = 11;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Command codes carried in tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_KEY_CODE      = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PRESS_COUNT   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LONG_COUNT    = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_RELEASE_COUNT = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic [THR_W-1:0] press_count;
    logic [THR_W-1:0] long_count;
    logic [THR_W-1:0] release_count;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } store_t;

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] last;
    last = IDX_W'(RING_DEPTH - 1);
    return (i == last) ? '0 : i + 1'b1;
  endfunction

endpackage

// ----- rtl/core/bplc_fsm.sv -----
module bplc_fsm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick,
  input  logic            pin_level,
  input  bplc_pkg::cfg_t  cfg,
  output bplc_pkg::store_t store
);
  import bplc_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_DEBOUNCE = 6'b000010,
    PH_HELD     = 6'b000100,
    PH_LONG     = 6'b001000,
    PH_RELEASE  = 6'b010000,
    PH_STORE    = 6'b100000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_bump;
  logic             long_r, long_nxt;
  logic             low;

  assign low      = ~pin_level;
  assign cnt_bump = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    long_nxt   = long_r;
    store      = '0;
    store.code = {long_r, cfg.key_code};
    if (tick) begin
      case (phase_r)
        PH_IDLE: begin
          if (low) begin
            cnt_nxt   = '0;
            long_nxt  = 1'b0;
            phase_nxt = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (low) begin
            cnt_nxt = cnt_bump;
            if (cnt_r >= CNT_W'(cfg.press_count)) phase_nxt = PH_HELD;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_HELD: begin
          // counter keeps running from the debounce count
          if (low) begin
            cnt_nxt = cnt_bump;
            if (cnt_r >= CNT_W'(cfg.long_count)) begin
              phase_nxt = PH_LONG;
              long_nxt  = 1'b1;
            end
          end else begin
            cnt_nxt   = '0;
            phase_nxt = PH_RELEASE;
          end
        end
        PH_LONG: begin
          if (!low) begin
            cnt_nxt   = '0;
            phase_nxt = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          // low samples are ignored here
          if (!low) begin
            cnt_nxt = cnt_bump;
            if (cnt_r > CNT_W'(cfg.release_count)) phase_nxt = PH_STORE;
          end
        end
        PH_STORE: begin
          store.valid = 1'b1;
          phase_nxt   = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      long_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

// ----- rtl/core/button_press_length_classifier_core.sv -----
// Button press classifier: each input word is either a tick carrying one pin sample (pressed
// when low) or a read command (tuser high). Ticks debounce the press, mark it long once the
// held count reaches long_count, wait for a debounced release and then push the key code,
// bit 7 set for a long press, into a four-entry ring that overwrites without a full check.
// A read returns one word: the next nonzero entry, which is cleared, or 0 when empty; ticks
// return nothing. One word is accepted every cycle unless a read is stalled. A word is held
// in the input register and processed from there; read results go to the output register.
// Only a read that finds the output register still held back stalls the input side.
module button_press_length_classifier_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [0] pin_level, [7:1] zero
  input  logic                        in_tuser,   // [0] cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] key_out
  input  logic                        cfg_we,
  input  logic [bplc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bplc_pkg::CFG_DW-1:0] cfg_wdata
);
  import bplc_pkg::*;

  `include "button_press_length_classifier_core_assert.svh"

  cfg_t              cfg_r;
  logic              s1_valid_r, s1_cmd_r, s1_pin_r;
  logic              adv, fire_tick, fire_rd;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_data_r;
  logic [CODE_W-1:0] ring_r [RING_DEPTH];
  logic [IDX_W-1:0]  wr_idx_r, rd_idx_r;
  logic [CODE_W-1:0] rd_word;
  store_t            store;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_code      <= KEY_W'(120);
      cfg_r.press_count   <= THR_W'(5);
      cfg_r.long_count    <= THR_W'(100);
      cfg_r.release_count <= THR_W'(5);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_KEY_CODE:      cfg_r.key_code      <= cfg_wdata[KEY_W-1:0];
        CFG_PRESS_COUNT:   cfg_r.press_count   <= cfg_wdata[THR_W-1:0];
        CFG_LONG_COUNT:    cfg_r.long_count    <= cfg_wdata[THR_W-1:0];
        CFG_RELEASE_COUNT: cfg_r.release_count <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // a read word waits in the input register while the result slot is blocked
  assign adv       = s1_valid_r && !(s1_cmd_r == CMD_READ && out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign fire_tick = adv && (s1_cmd_r == CMD_TICK);
  assign fire_rd   = adv && (s1_cmd_r == CMD_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tuser;
      s1_pin_r <= in_tdata[0];
    end
  end

  bplc_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (fire_tick),
    .pin_level (s1_pin_r),
    .cfg       (cfg_r),
    .store     (store)
  );

  assign rd_word = ring_r[rd_idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= '0;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      if (store.valid) begin
        ring_r[wr_idx_r] <= store.code;
        wr_idx_r         <= next_index(wr_idx_r);
      end
      if (fire_rd && rd_word != '0) begin
        ring_r[rd_idx_r] <= '0;
        rd_idx_r         <= next_index(rd_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_rd) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_rd) out_data_r <= rd_word;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `BPLC_ASSERT_NEXT(a_read_gives_word, fire_rd, out_tvalid)
  `BPLC_ASSERT_NEXT(a_empty_read_holds_idx, fire_rd && rd_word == '0, $stable(rd_idx_r))
  `BPLC_ASSERT_NEXT(a_store_moves_wr_idx, store.valid, wr_idx_r != $past(wr_idx_r))
  `BPLC_ASSERT_SAME(a_no_tick_store_on_read, store.valid, fire_tick)

endmodule
